// File: rtl/sorted_clause_subsumption_check_assert.svh
// ============================================================================
// Assertion macros for the sorted clause subsumption check
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ============================================================================
`ifndef SORTED_CLAUSE_SUBSUMPTION_CHECK_ASSERT_SVH
`define SORTED_CLAUSE_SUBSUMPTION_CHECK_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define SCS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SCS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scs_pkg.sv
// ============================================================================
// Sorted clause subsumption check package
// Operation codes of the input channel.
// ============================================================================
package scs_pkg;

  localparam int unsigned OpWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_LOAD = 2'd0,
    OP_TEST = 2'd1,
    OP_END  = 2'd2
  } op_e;

endpackage

// File: rtl/scs_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ============================================================================
module scs_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sorted_clause_subsumption_check.sv
// A load or end transfer does not enter the scan state. A test transfer starts a scan of the
// stored literals, in which a single signed comparator checks one stored literal per cycle
// against the registered read port of the clause memory; the scan ends on an equal literal,
// on a larger one or when it runs off the end of the list, and a test after a failure or
// with the pointer already at the end does not scan. The input is stalled until the scan
// ends. A result is held in an output register, and the input is also stalled while that
// register holds a result that the receiver is stalling. There is no clearing pass after
// reset: only entries below the stored count are ever read.
// ============================================================================
// Sorted clause subsumption check
// Stores a sorted weaker clause and tests a sorted stronger clause against it
// one literal at a time with a forward scan pointer.
// ============================================================================
module sorted_clause_subsumption_check #(
  parameter int unsigned MAX_CLAUSE_LEN = 64,
  parameter int unsigned LIT_WIDTH      = 21
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [scs_pkg::OpWidth-1:0] operation_i,
  input  logic signed [LIT_WIDTH-1:0] literal_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_subset_o,
  output logic                        overflowed_o
);

  localparam int unsigned CntW  = $clog2(MAX_CLAUSE_LEN + 1);
  localparam int unsigned AddrW = (MAX_CLAUSE_LEN > 1) ? $clog2(MAX_CLAUSE_LEN) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CLAUSE_LEN);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                        state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [CntW-1:0]             ptr_q, ptr_d;
  logic                        failed_q, failed_d;
  logic                        ovf_q, ovf_d;
  logic                        start_q, start_d;
  logic signed [LIT_WIDTH-1:0] lit_q, lit_d;
  logic                        out_valid_q, out_valid_d;
  logic                        subset_q, subset_d;
  logic                        ovf_out_q, ovf_out_d;

  logic                        in_acc;
  logic [CntW-1:0]             cnt_eff;
  logic [CntW-1:0]             ptr_next;
  logic                        ram_we;
  logic                        ram_re;
  logic [AddrW-1:0]            ram_waddr;
  logic [AddrW-1:0]            ram_raddr;
  logic [LIT_WIDTH-1:0]        ram_rdata;
  logic signed [LIT_WIDTH-1:0] ram_lit;

  scs_ram #(
    .WIDTH(LIT_WIDTH),
    .DEPTH(MAX_CLAUSE_LEN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(literal_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_lit    = $signed(ram_rdata);
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_eff    = start_q ? '0 : count_q;
  assign ptr_next   = ptr_q + 1'b1;
  assign ram_waddr  = cnt_eff[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    failed_d    = failed_q;
    ovf_d       = ovf_q;
    start_d     = start_q;
    lit_d       = lit_q;
    out_valid_d = out_valid_q;
    subset_d    = subset_q;
    ovf_out_d   = ovf_out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q[AddrW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (scs_pkg::op_e'(operation_i))
            scs_pkg::OP_LOAD: begin
              if (start_q) begin
                ptr_d    = '0;
                failed_d = 1'b0;
                ovf_d    = 1'b0;
              end
              count_d = cnt_eff;
              if (cnt_eff < MaxCnt) begin
                ram_we  = 1'b1;
                count_d = cnt_eff + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
              start_d = last_i;
            end
            scs_pkg::OP_TEST: begin
              if (!failed_q) begin
                if (ptr_q == count_q) begin
                  failed_d = 1'b1;
                end else begin
                  ram_re  = 1'b1;
                  lit_d   = literal_i;
                  state_d = StScan;
                end
              end
            end
            scs_pkg::OP_END: begin
              out_valid_d = 1'b1;
              subset_d    = !failed_q;
              ovf_out_d   = ovf_q;
              ptr_d       = '0;
              failed_d    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      StScan: begin
        if (ram_lit < lit_q) begin
          ptr_d = ptr_next;
          if (ptr_next == count_q) begin
            failed_d = 1'b1;
            state_d  = StIdle;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_next[AddrW-1:0];
          end
        end else if (ram_lit == lit_q) begin
          ptr_d   = ptr_next;
          state_d = StIdle;
        end else begin
          failed_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      ptr_q       <= '0;
      failed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      failed_q    <= failed_d;
      ovf_q       <= ovf_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lit_q     <= lit_d;
    subset_q  <= subset_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign is_subset_o  = subset_q;
  assign overflowed_o = ovf_out_q;

`include "sorted_clause_subsumption_check_assert.svh"

  `SCS_ASSERT_ALWAYS(a_ptr_in_range, ptr_q <= count_q, "Scan pointer passed the stored count.")
  `SCS_ASSERT_IMPLY(a_scan_ptr, state_q == StScan, ptr_q < count_q, "Scan read past the list.")
  `SCS_ASSERT_IMPLY(a_scan_not_failed, state_q == StScan, !failed_q, "Scan after a failure.")
  `SCS_ASSERT_IMPLY(a_ovf_full, ovf_q, count_q == MaxCnt, "Overflow with room in the store.")
  `SCS_ASSERT_NEXT(a_end_rearms, in_acc && operation_i == scs_pkg::OP_END,
                   !failed_q && ptr_q == '0, "End did not rearm the scan.")

endmodule
